// ----- rtl/core/reu_pkg.sv -----
// reu_pkg: shared types, constants and helpers for the Riccati Euler step block.
// Used by reu_ctrl, reu_dpath and riccati_euler_gain_update. No dependencies.
package reu_pkg;

  localparam int AddrW    = 6;
  localparam int MemDepth = 60;
  localparam int AccW     = 51;

  // Scratch memory map: nine-word matrices and three-word vectors
  localparam logic [AddrW-1:0] P_BASE   = 6'd0;
  localparam logic [AddrW-1:0] U0_BASE  = 6'd9;
  localparam logic [AddrW-1:0] T1_BASE  = 6'd12;
  localparam logic [AddrW-1:0] TA_BASE  = 6'd21;
  localparam logic [AddrW-1:0] TB_BASE  = 6'd30;
  localparam logic [AddrW-1:0] DP_BASE  = 6'd39;
  localparam logic [AddrW-1:0] VA_BASE  = 6'd48;
  localparam logic [AddrW-1:0] VB_BASE  = 6'd51;
  localparam logic [AddrW-1:0] TMP_BASE = 6'd54;
  localparam logic [AddrW-1:0] DU_BASE  = 6'd57;

  localparam logic [3:0] U_BASE = 4'd9;   // strain words in the input capture

  localparam logic signed [31:0] FX_ONE     = 32'sd65536;
  localparam logic signed [31:0] FX_NEG_ONE = -32'sd65536;
  localparam logic signed [31:0] FX_NEG_TWO = -32'sd131072;

  typedef enum logic [1:0] {
    REG_STEP_SIZE     = 2'd0,
    REG_VELOCITY_GAIN = 2'd1,
    REG_STATE_WEIGHT  = 2'd2,
    REG_INPUT_WEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    A_MEM, A_INP, A_VGAIN, A_RWT, A_STEP, A_QW, A_ZERO, A_ONE, A_MONE, A_MTWO
  } asel_t;

  typedef enum logic [1:0] {
    B_MEM, B_INP, B_ONE
  } bsel_t;

  typedef struct packed {
    asel_t            a_sel;
    bsel_t            b_sel;
    logic [AddrW-1:0] a_addr;
    logic [AddrW-1:0] b_addr;
    logic [3:0]       inp_idx;
    logic [AddrW-1:0] wr_addr;
    logic             first;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic ld;      // capture input word, clear flag
    logic rd;      // read operands
    logic mul;     // register product
    logic acc;     // round, accumulate, write back on last term
    logic out_ld;  // move result into output register
  } ctl_t;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    idx3 = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [AddrW-1:0] at(input logic [AddrW-1:0] base,
                                          input logic [3:0] off);
    at = base + {{(AddrW-4){1'b0}}, off};
  endfunction

  // Reset content of P (identity) and everything else reads zero
  function automatic logic [31:0] init_val(input logic [AddrW-1:0] a);
    if (a == P_BASE || a == at(P_BASE, 4'd4) || a == at(P_BASE, 4'd8))
      init_val = FX_ONE;
    else
      init_val = 32'd0;
  endfunction

endpackage

// ----- rtl/core/riccati_euler_gain_update.sv -----
// riccati_euler_gain_update: top level of the 3x3 Riccati Euler step block.
// Instantiates reu_ctrl and reu_dpath; types and constants from reu_pkg.
//
// Usage:
//  - Input word: Gamma (g00..g22, row-major) plus final strain (strain_x/y/z),
//    all signed Q16.16, taken when in_valid is high and in_stall is low.
//  - Output word: updated u0 (init_x/y/z) plus a saturated flag, offered on
//    out_valid and held stable while out_stall is high.
//  - Config: cfg_write with cfg_index 0..3 (step, velocity gain, state weight,
//    input weight) and cfg_data; other indexes are dropped. Write only idle.
//  - Sequence: 174 MAC terms, each run as operand read, multiply and
//    round/accumulate on the one shared multiplier, followed by an output
//    load that raises out_valid.
//  - Flow: no word is accepted while one is in work; the next word is
//    accepted as soon as the previous result sits in the output register,
//    even if stalled. A stalled result delays only the following hand-off.
//  - Reset (rst, synchronous): P returns to identity, u0 to zero, registers
//    to their defaults, and no word is in flight.
module riccati_euler_gain_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] g00, g01, g02, g10, g11, g12, g20, g21, g22,
  input  logic signed [31:0] strain_x, strain_y, strain_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] init_x,
  output logic signed [31:0] init_y,
  output logic signed [31:0] init_z,
  output logic               saturated
);

  reu_pkg::ctl_t ctl;
  reu_pkg::cmd_t cmd;

  // sequencer: term walk, handshakes
  reu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .cmd       (cmd)
  );

  // storage and shared MAC
  reu_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .g00 (g00), .g01 (g01), .g02 (g02),
    .g10 (g10), .g11 (g11), .g12 (g12),
    .g20 (g20), .g21 (g21), .g22 (g22),
    .strain_x  (strain_x),
    .strain_y  (strain_y),
    .strain_z  (strain_z),
    .init_x    (init_x),
    .init_y    (init_y),
    .init_z    (init_z),
    .saturated (saturated)
  );

  // accepted word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

  // a new result only appears after work was in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a step in progress");

  // idle with no offer stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !in_stall)
    else $error("block left idle without an input word");

endmodule

// ----- rtl/core/reu_dpath.sv -----
// reu_dpath: operand memory, input capture, config registers, shared MAC and
// output register. Depends on reu_pkg; sequenced by reu_ctrl.
module reu_dpath (
  input  logic                clk,
  input  logic                rst,
  input  reu_pkg::ctl_t       ctl,
  input  reu_pkg::cmd_t       cmd,
  input  logic                cfg_write,
  input  logic [3:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  g00, g01, g02, g10, g11, g12, g20, g21, g22,
  input  logic signed [31:0]  strain_x, strain_y, strain_z,
  output logic signed [31:0]  init_x,
  output logic signed [31:0]  init_y,
  output logic signed [31:0]  init_z,
  output logic                saturated
);

  localparam logic signed [reu_pkg::AccW-1:0] SatMax = reu_pkg::AccW'(64'sd2147483647);
  localparam logic signed [reu_pkg::AccW-1:0] SatMin = reu_pkg::AccW'(-64'sd2147483648);

  logic [30:0]        step_size;
  logic signed [31:0] velocity_gain, state_weight, input_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size     <= 31'd655;
      velocity_gain <= '0;
      state_weight  <= '0;
      input_weight  <= '0;
    end else if (cfg_write && cfg_index[3:2] == 2'b00) begin
      case (reu_pkg::reg_idx_t'(cfg_index[1:0]))
        reu_pkg::REG_STEP_SIZE:     step_size     <= cfg_data[30:0];
        reu_pkg::REG_VELOCITY_GAIN: velocity_gain <= cfg_data;
        reu_pkg::REG_STATE_WEIGHT:  state_weight  <= cfg_data;
        reu_pkg::REG_INPUT_WEIGHT:  input_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word capture
  logic signed [31:0] gin [12];
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      gin[0] <= g00; gin[1] <= g01; gin[2]  <= g02;
      gin[3] <= g10; gin[4] <= g11; gin[5]  <= g12;
      gin[6] <= g20; gin[7] <= g21; gin[8]  <= g22;
      gin[9] <= strain_x; gin[10] <= strain_y; gin[11] <= strain_z;
    end
  end

  // scratch memory, two registered reads, one write
  logic [31:0] mem [reu_pkg::MemDepth];
  logic [reu_pkg::MemDepth-1:0] vld;
  logic [31:0] rda, rdb, inia, inib;
  logic        vla, vlb;
  logic signed [31:0] inp;
  logic signed [31:0] wdata;
  logic        wr_en;

  assign wr_en = ctl.acc && cmd.last;

  always_ff @(posedge clk) begin
    if (wr_en) mem[cmd.wr_addr] <= wdata;
    if (ctl.rd) begin
      rda <= mem[cmd.a_addr];
      rdb <= mem[cmd.b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (wr_en) vld[cmd.wr_addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      vla  <= vld[cmd.a_addr];
      vlb  <= vld[cmd.b_addr];
      inia <= reu_pkg::init_val(cmd.a_addr);
      inib <= reu_pkg::init_val(cmd.b_addr);
      inp  <= gin[cmd.inp_idx];
    end
  end

  // operand select and multiply
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod;

  always_comb begin
    case (cmd.a_sel)
      reu_pkg::A_MEM:   opa = vla ? rda : inia;
      reu_pkg::A_INP:   opa = inp;
      reu_pkg::A_VGAIN: opa = velocity_gain;
      reu_pkg::A_RWT:   opa = input_weight;
      reu_pkg::A_STEP:  opa = {1'b0, step_size};
      reu_pkg::A_QW:    opa = state_weight;
      reu_pkg::A_ONE:   opa = reu_pkg::FX_ONE;
      reu_pkg::A_MONE:  opa = reu_pkg::FX_NEG_ONE;
      reu_pkg::A_MTWO:  opa = reu_pkg::FX_NEG_TWO;
      default:          opa = '0;
    endcase
    case (cmd.b_sel)
      reu_pkg::B_MEM: opb = vlb ? rdb : inib;
      reu_pkg::B_INP: opb = inp;
      reu_pkg::B_ONE: opb = reu_pkg::FX_ONE;
      default:        opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) prod <= opa * opb;
  end

  // round half up, exact accumulate, clamp on the last term
  logic signed [63:0] prod_r;
  logic signed [reu_pkg::AccW-1:0] acc, acc_sum;
  logic clamp_hi, clamp_lo;

  assign prod_r   = prod + 64'sd32768;
  assign acc_sum  = (cmd.first ? '0 : acc) + reu_pkg::AccW'(signed'(prod_r[63:16]));
  assign clamp_hi = acc_sum > SatMax;
  assign clamp_lo = acc_sum < SatMin;

  always_comb begin
    if (clamp_hi)      wdata = 32'sh7FFFFFFF;
    else if (clamp_lo) wdata = 32'sh80000000;
    else               wdata = acc_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) acc <= acc_sum;
  end

  // per-word saturation flag and u0 staging
  logic sat_seen;
  logic signed [31:0] res [3];
  logic [reu_pkg::AddrW-1:0] u_off;

  assign u_off = cmd.wr_addr - reu_pkg::U0_BASE;

  always_ff @(posedge clk) begin
    if (rst) sat_seen <= 1'b0;
    else if (ctl.ld) sat_seen <= 1'b0;
    else if (wr_en && (clamp_hi || clamp_lo)) sat_seen <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en && cmd.wr_addr >= reu_pkg::U0_BASE && u_off < 6'd3)
      res[u_off[1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      init_x    <= res[0];
      init_y    <= res[1];
      init_z    <= res[2];
      saturated <= sat_seen;
    end
  end

endmodule

// ----- rtl/core/reu_ctrl.sv -----
// reu_ctrl: sequencer for one Euler step; walks the term list and drives the
// datapath with commands and strobes. Depends on reu_pkg.
module reu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output reu_pkg::ctl_t  ctl,
  output reu_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_MUL   = 5'b00100,
    S_ACC   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [11:0] {
    PH_T1   = 12'b000000000001,
    PH_GTP  = 12'b000000000010,
    PH_RTA  = 12'b000000000100,
    PH_GTB  = 12'b000000001000,
    PH_PTA  = 12'b000000010000,
    PH_DP   = 12'b000000100000,
    PH_PU   = 12'b000001000000,
    PH_GTVA = 12'b000010000000,
    PH_RVB  = 12'b000100000000,
    PH_NEG  = 12'b001000000000,
    PH_UPDP = 12'b010000000000,
    PH_UPDU = 12'b100000000000
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [1:0] i, j, k, i_next, j_next, k_next;
  logic [1:0] k_max, j_max;
  logic [3:0] e, ik, kj, ki;
  logic       out_valid_next;

  assign e  = reu_pkg::idx3(i, j);
  assign ik = reu_pkg::idx3(i, k);
  assign kj = reu_pkg::idx3(k, j);
  assign ki = reu_pkg::idx3(k, i);

  always_comb begin
    cmd         = '0;
    cmd.a_sel   = reu_pkg::A_MEM;
    cmd.b_sel   = reu_pkg::B_MEM;
    cmd.first   = (k == 2'd0);
    k_max       = 2'd2;
    j_max       = 2'd2;
    case (phase)
      PH_T1: begin
        k_max = 2'd0;
        cmd.a_sel = reu_pkg::A_VGAIN;
        cmd.b_addr = reu_pkg::at(reu_pkg::P_BASE, e);
        cmd.wr_addr = reu_pkg::at(reu_pkg::T1_BASE, e);
      end
      PH_GTP: begin
        cmd.a_sel = reu_pkg::A_INP;
        cmd.inp_idx = ki;
        cmd.b_addr = reu_pkg::at(reu_pkg::P_BASE, kj);
        cmd.wr_addr = reu_pkg::at(reu_pkg::TA_BASE, e);
      end
      PH_RTA: begin
        k_max = 2'd0;
        cmd.a_sel = reu_pkg::A_RWT;
        cmd.b_addr = reu_pkg::at(reu_pkg::TA_BASE, e);
        cmd.wr_addr = reu_pkg::at(reu_pkg::TB_BASE, e);
      end
      PH_GTB: begin
        cmd.a_sel = reu_pkg::A_INP;
        cmd.inp_idx = ik;
        cmd.b_addr = reu_pkg::at(reu_pkg::TB_BASE, kj);
        cmd.wr_addr = reu_pkg::at(reu_pkg::TA_BASE, e);
      end
      PH_PTA: begin
        cmd.a_addr = reu_pkg::at(reu_pkg::P_BASE, ik);
        cmd.b_addr = reu_pkg::at(reu_pkg::TA_BASE, kj);
        cmd.wr_addr = reu_pkg::at(reu_pkg::TB_BASE, e);
      end
      PH_DP: begin
        // -2*T1 - T2 + q on the diagonal, each as an exact term
        cmd.wr_addr = reu_pkg::at(reu_pkg::DP_BASE, e);
        case (k)
          2'd0: begin
            cmd.a_sel = reu_pkg::A_MTWO;
            cmd.b_addr = reu_pkg::at(reu_pkg::T1_BASE, e);
          end
          2'd1: begin
            cmd.a_sel = reu_pkg::A_MONE;
            cmd.b_addr = reu_pkg::at(reu_pkg::TB_BASE, e);
          end
          default: begin
            cmd.a_sel = (i == j) ? reu_pkg::A_QW : reu_pkg::A_ZERO;
            cmd.b_sel = reu_pkg::B_ONE;
          end
        endcase
      end
      PH_PU: begin
        j_max = 2'd0;
        cmd.a_addr = reu_pkg::at(reu_pkg::P_BASE, ik);
        cmd.b_sel = reu_pkg::B_INP;
        cmd.inp_idx = reu_pkg::U_BASE + {2'b00, k};
        cmd.wr_addr = reu_pkg::at(reu_pkg::VA_BASE, {2'b00, i});
      end
      PH_GTVA: begin
        j_max = 2'd0;
        cmd.a_sel = reu_pkg::A_INP;
        cmd.inp_idx = ki;
        cmd.b_addr = reu_pkg::at(reu_pkg::VA_BASE, {2'b00, k});
        cmd.wr_addr = reu_pkg::at(reu_pkg::VB_BASE, {2'b00, i});
      end
      PH_RVB: begin
        j_max = 2'd0;
        k_max = 2'd0;
        cmd.a_sel = reu_pkg::A_RWT;
        cmd.b_addr = reu_pkg::at(reu_pkg::VB_BASE, {2'b00, i});
        cmd.wr_addr = reu_pkg::at(reu_pkg::TMP_BASE, {2'b00, i});
      end
      PH_NEG: begin
        j_max = 2'd0;
        k_max = 2'd0;
        cmd.a_sel = reu_pkg::A_MONE;
        cmd.b_addr = reu_pkg::at(reu_pkg::TMP_BASE, {2'b00, i});
        cmd.wr_addr = reu_pkg::at(reu_pkg::DU_BASE, {2'b00, i});
      end
      PH_UPDP: begin
        k_max = 2'd1;
        cmd.wr_addr = reu_pkg::at(reu_pkg::P_BASE, e);
        if (k == 2'd0) begin
          cmd.a_sel = reu_pkg::A_ONE;
          cmd.b_addr = reu_pkg::at(reu_pkg::P_BASE, e);
        end else begin
          cmd.a_sel = reu_pkg::A_STEP;
          cmd.b_addr = reu_pkg::at(reu_pkg::DP_BASE, e);
        end
      end
      PH_UPDU: begin
        j_max = 2'd0;
        k_max = 2'd1;
        cmd.wr_addr = reu_pkg::at(reu_pkg::U0_BASE, {2'b00, i});
        if (k == 2'd0) begin
          cmd.a_sel = reu_pkg::A_ONE;
          cmd.b_addr = reu_pkg::at(reu_pkg::U0_BASE, {2'b00, i});
        end else begin
          cmd.a_sel = reu_pkg::A_STEP;
          cmd.b_addr = reu_pkg::at(reu_pkg::DU_BASE, {2'b00, i});
        end
      end
      default: ;
    endcase
    cmd.last = (k == k_max);
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    i_next = i;
    j_next = j;
    k_next = k;
    ctl = '0;
    in_stall = (state != S_IDLE);
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld = 1'b1;
          phase_next = PH_T1;
          i_next = '0;
          j_next = '0;
          k_next = '0;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctl.rd = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctl.acc = 1'b1;
        state_next = S_ISSUE;
        if (k != k_max) begin
          k_next = k + 2'd1;
        end else begin
          k_next = '0;
          if (j != j_max) begin
            j_next = j + 2'd1;
          end else begin
            j_next = '0;
            if (i != 2'd2) begin
              i_next = i + 2'd1;
            end else begin
              i_next = '0;
              case (phase)
                PH_T1:   phase_next = PH_GTP;
                PH_GTP:  phase_next = PH_RTA;
                PH_RTA:  phase_next = PH_GTB;
                PH_GTB:  phase_next = PH_PTA;
                PH_PTA:  phase_next = PH_DP;
                PH_DP:   phase_next = PH_PU;
                PH_PU:   phase_next = PH_GTVA;
                PH_GTVA: phase_next = PH_RVB;
                PH_RVB:  phase_next = PH_NEG;
                PH_NEG:  phase_next = PH_UPDP;
                PH_UPDP: phase_next = PH_UPDU;
                default: state_next = S_DONE;
              endcase
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          ctl.out_ld = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_T1;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
